// ===== hw/rtl/utf8pc_pkg.sv =====
// Shared constants and decode helpers for the UTF-8 printable character counter.
// No dependencies; imported by the top level, the checker and the bench.
package utf8pc_pkg;

    localparam int unsigned CP_WIDTH  = 42;
    localparam int unsigned LEN_WIDTH = 4;
    localparam int unsigned REM_WIDTH = 3;
    localparam int unsigned OUT_COUNT_WIDTH = 16;

    typedef logic [CP_WIDTH-1:0]  t_cp_value;
    typedef logic [LEN_WIDTH-1:0] t_seq_len;
    typedef logic [REM_WIDTH-1:0] t_remaining;

    localparam logic [7:0]  CONT_MASK = 8'h3F;
    localparam t_cp_value   CP_SPACE  = 42'h20;
    localparam t_cp_value   CP_NBSP   = 42'h00A0;
    localparam t_cp_value   CP_CGJ    = 42'h034F;
    localparam t_cp_value   CP_SP_LO  = 42'h2000;
    localparam t_cp_value   CP_SP_HI  = 42'h200F;
    localparam t_cp_value   CP_BD_LO  = 42'h202A;
    localparam t_cp_value   CP_BD_HI  = 42'h202F;
    localparam t_cp_value   CP_MS_LO  = 42'h205F;
    localparam t_cp_value   CP_MS_HI  = 42'h2063;
    localparam t_cp_value   CP_BOM    = 42'hFEFF;
    localparam t_cp_value   CP_REPL   = 42'hFFFD;
    localparam t_cp_value   CP_NONCH  = 42'hFFFE;

    localparam t_seq_len LEN_ONE = 4'd1;
    localparam t_seq_len LEN_MAX = 4'd8;

    function automatic t_seq_len f_lead_len(input logic [7:0] b);
        t_seq_len len;
        logic     run;
        len = LEN_ONE;
        run = b[7];
        for (int k = 6; k >= 0; k--) begin
            if (run && b[k]) begin
                len = len + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return len;
    endfunction

    function automatic logic f_printable(input t_cp_value cp);
        logic ok;
        ok = 1'b1;
        if (cp <= CP_SPACE) ok = 1'b0;
        if (cp == CP_NBSP || cp == CP_CGJ) ok = 1'b0;
        if (cp >= CP_SP_LO && cp <= CP_SP_HI) ok = 1'b0;
        if (cp >= CP_BD_LO && cp <= CP_BD_HI) ok = 1'b0;
        if (cp >= CP_MS_LO && cp <= CP_MS_HI) ok = 1'b0;
        if (cp == CP_BOM || cp == CP_REPL || cp == CP_NONCH) ok = 1'b0;
        return ok;
    endfunction

endpackage

// ===== hw/rtl/utf8_printable_char_counter_top.sv =====
// Top level of the UTF-8 printable character counter: input register, decode, result register.
// Depends on utf8pc_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one byte per beat (i_data_byte) and
//   i_end_of_string on the final byte of each string.
//   Output channel: o_out_valid / i_out_stall carry one decoded code point per beat with
//   its printable flag, announced length, truncation flag, running printable count and
//   o_last on the final code point of a string.
//   Mid-sequence bytes give no output beat unless they end the sequence or the string.
//   Decode and count update are one registered pass from the input to the result register.
//   Throughput: one byte per cycle while i_out_stall does not hold a waiting result.
//   Stall: while i_out_stall holds a waiting result, the input register still takes one
//   more byte; out of reset, o_in_stall rises only when input and result registers are full.
//   Reset (synchronous, active low): empties both registers, clears the decode state and
//   the printable count, and sets the announced length to one; o_in_stall stays high and
//   o_out_valid low while reset is held.
//   The printable count saturates at 2**COUNT_WIDTH - 1 and shows its low 16 bits.
module utf8_printable_char_counter_top #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [41:0] o_cp_value,
    output logic        o_is_printable,
    output logic [3:0]  o_seq_length,
    output logic        o_truncated,
    output logic [15:0] o_printable_count,
    output logic        o_last
);
    import utf8pc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eos;

    t_cp_value   r_acc;
    t_remaining  r_rem;
    t_seq_len    r_len;
    logic [COUNT_WIDTH-1:0] r_count;

    logic        r_out_valid;
    t_cp_value   r_out_cp;
    logic        r_out_ok;
    t_seq_len    r_out_len;
    logic        r_out_trunc;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic        r_out_last;

    logic        out_free;
    logic        in_free;
    logic        fire;
    logic        emit;
    t_seq_len    lead_len;
    t_cp_value   n_acc;
    t_remaining  n_rem;
    t_seq_len    n_len;
    logic        n_ok;
    logic [COUNT_WIDTH-1:0] n_count;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_free    = !r_in_valid || out_free;
    assign o_in_stall = !in_free || !i_rst_n;
    assign fire       = r_in_valid && out_free;

    always_comb begin
        lead_len = f_lead_len(r_in_byte);
        if (r_rem == '0) begin
            if (!r_in_byte[7]) begin
                n_acc = CP_WIDTH'(r_in_byte);
            end else begin
                n_acc = CP_WIDTH'(r_in_byte & (CONT_MASK >> (lead_len - LEN_ONE)));
            end
            n_rem = REM_WIDTH'(lead_len - LEN_ONE);
            n_len = lead_len;
        end else begin
            n_acc = {r_acc[CP_WIDTH-7:0], r_in_byte[5:0]};
            n_rem = r_rem - 3'd1;
            n_len = r_len;
        end
        emit = (n_rem == '0) || r_in_eos;
        n_ok = f_printable(n_acc);
        n_count = r_count;
        if (n_ok && r_count != COUNT_MAX) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_string;
        end
    end

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_rem   <= '0;
            r_len   <= LEN_ONE;
            r_count <= '0;
        end else if (fire) begin
            if (r_in_eos) begin
                r_acc   <= '0;
                r_rem   <= '0;
                r_len   <= LEN_ONE;
                r_count <= '0;
            end else begin
                r_acc <= n_acc;
                r_rem <= n_rem;
                r_len <= n_len;
                if (emit) begin
                    r_count <= n_count;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_cp    <= n_acc;
            r_out_ok    <= n_ok;
            r_out_len   <= n_len;
            r_out_trunc <= (n_rem != '0);
            r_out_count <= n_count;
            r_out_last  <= r_in_eos;
        end
    end

    assign o_out_valid       = r_out_valid && i_rst_n;
    assign o_cp_value        = r_out_cp;
    assign o_is_printable    = r_out_ok;
    assign o_seq_length      = r_out_len;
    assign o_truncated       = r_out_trunc;
    assign o_printable_count = OUT_COUNT_WIDTH'(r_out_count);
    assign o_last            = r_out_last;

endmodule

// ===== hw/rtl/utf8pc_checker.sv =====
// Port-level checks for the UTF-8 printable character counter, bound to its top level.
// Depends on utf8pc_pkg and utf8_printable_char_counter_top.
module utf8pc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [41:0] o_cp_value,
    input logic        o_is_printable,
    input logic [3:0]  o_seq_length,
    input logic        o_truncated,
    input logic        o_last
);
    import utf8pc_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cp_value))
        else $error("stalled result beat changed");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_seq_length >= LEN_ONE) && (o_seq_length <= LEN_MAX))
        else $error("announced length out of range");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_last && (o_seq_length != LEN_ONE))
        else $error("truncated beat not at string end or from a one-byte sequence");

    a_ctrl_not_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_cp_value <= CP_SPACE) |-> !o_is_printable)
        else $error("control or space code point flagged printable");

endmodule

bind utf8_printable_char_counter_top utf8pc_checker u_utf8pc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_cp_value     (o_cp_value),
    .o_is_printable (o_is_printable),
    .o_seq_length   (o_seq_length),
    .o_truncated    (o_truncated),
    .o_last         (o_last)
);

// ===== verif/tb_utf8_printable_char_counter_top.sv =====
// Self-checking bench for utf8_printable_char_counter_top: byte beats in, decoded code points out.
// Depends on utf8pc_pkg and the top level; the expected results come from a decoder model below.
`timescale 1ns / 1ps

module tb_utf8_printable_char_counter_top;

    import utf8pc_pkg::*;

    localparam int unsigned CNT_W      = 16;
    localparam logic [32:0] COUNT_TOP  = (33'd1 << CNT_W) - 33'd1;
    localparam int unsigned RAND_BEATS = 1120;
    localparam int unsigned HOLD_AT    = 400;
    localparam int unsigned HOLD_LEN   = 300;
    localparam int unsigned IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_byte_beat;

    typedef struct packed {
        t_cp_value   cp;
        logic        prn;
        t_seq_len    len;
        logic        trunc;
        logic [15:0] count;
        logic        last;
    } t_cp_result;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} t_rx_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_string = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [41:0] cp_value;
    logic        is_printable;
    logic [3:0]  seq_length;
    logic        truncated;
    logic [15:0] printable_count;
    logic        last;

    t_byte_beat  pend_beats[$];
    t_cp_result  exp_results[$];
    int unsigned mismatches = 0;

    t_cp_value   dec_acc   = '0;
    t_remaining  dec_rem   = '0;
    t_seq_len    dec_len   = LEN_ONE;
    logic [32:0] dec_count = '0;

    utf8_printable_char_counter_top #(
        .COUNT_WIDTH(CNT_W)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (data_byte),
        .i_end_of_string  (end_of_string),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_cp_value       (cp_value),
        .o_is_printable   (is_printable),
        .o_seq_length     (seq_length),
        .o_truncated      (truncated),
        .o_printable_count(printable_count),
        .o_last           (last)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic visible(input t_cp_value cp);
        if (cp <= CP_SPACE || cp == CP_NBSP || cp == CP_CGJ) return 1'b0;
        if (cp >= CP_SP_LO && cp <= CP_SP_HI) return 1'b0;
        if (cp >= CP_BD_LO && cp <= CP_BD_HI) return 1'b0;
        if (cp >= CP_MS_LO && cp <= CP_MS_HI) return 1'b0;
        return cp != CP_BOM && cp != CP_REPL && cp != CP_NONCH;
    endfunction

    function void decode_byte(input logic [7:0] b, input logic eos);
        t_cp_result r;
        int         k;
        if (dec_rem == 0) begin
            dec_len = LEN_ONE;
            if (b[7]) begin
                k = 6;
                while (k >= 0) begin
                    if (!b[k]) break;
                    dec_len = dec_len + 4'd1;
                    k--;
                end
                dec_acc = (dec_len < 7) ? t_cp_value'(b & (CONT_MASK >> (dec_len - 1))) : '0;
            end else begin
                dec_acc = t_cp_value'(b);
            end
            dec_rem = t_remaining'(dec_len - 1);
        end else begin
            dec_acc = {dec_acc[CP_WIDTH-7:0], b[5:0]};
            dec_rem = dec_rem - 3'd1;
        end
        if (dec_rem != 0 && !eos) return;
        r.cp    = dec_acc;
        r.prn   = visible(dec_acc);
        r.len   = dec_len;
        r.trunc = dec_rem != 0;
        if (r.prn && dec_count < COUNT_TOP) dec_count = dec_count + 33'd1;
        r.count = dec_count[15:0];
        r.last  = eos;
        exp_results.insert(exp_results.size(), r);
        if (eos) begin
            dec_acc   = '0;
            dec_rem   = '0;
            dec_len   = LEN_ONE;
            dec_count = '0;
        end
    endfunction

    task automatic push_beat(input logic [7:0] b);
        t_byte_beat beat;
        beat.data = b;
        beat.eos  = 1'b0;
        pend_beats.insert(pend_beats.size(), beat);
    endtask

    task automatic close_string();
        t_byte_beat beat;
        beat = pend_beats.pop_back();
        beat.eos = 1'b1;
        pend_beats.insert(pend_beats.size(), beat);
    endtask

    // Encode v as a len-byte sequence, optionally garbling continuation bytes; emit nbytes of it.
    task automatic add_cp(input t_cp_value v, input int unsigned len,
                          input int unsigned nbytes, input bit garble);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++) begin
            if (i == 0) begin
                if (len == 1) b = {1'b0, v[6:0]};
                else b = (8'hFF << (8 - len)) |
                         (8'(v >> (6 * (len - 1))) & (CONT_MASK >> (len - 1)));
            end else begin
                b = 8'h80 | (8'(v >> (6 * (len - 1 - i))) & CONT_MASK);
                if (garble && $urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
            end
            push_beat(b);
        end
    endtask

    function automatic int unsigned payload_bits(input int unsigned len);
        if (len == 1) return 7;
        if (len >= 7) return 6 * (len - 1);
        return (7 - len) + 6 * (len - 1);
    endfunction

    function automatic t_cp_value pick_special();
        case ($urandom_range(0, 11))
            0:       return CP_SPACE;
            1:       return CP_NBSP;
            2:       return CP_CGJ;
            3:       return CP_SP_LO + t_cp_value'($urandom_range(0, 15));
            4:       return CP_BD_LO + t_cp_value'($urandom_range(0, 5));
            5:       return CP_MS_LO + t_cp_value'($urandom_range(0, 4));
            6:       return CP_BOM;
            7:       return CP_REPL;
            8:       return CP_NONCH;
            9:       return CP_SPACE + t_cp_value'(1);
            10:      return CP_SP_LO - t_cp_value'(1);
            default: return CP_MS_HI + t_cp_value'(1);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Sender: bursts of beats with random gaps; the payload holds while stalled.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk) begin
        t_byte_beat beat;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) decode_byte(data_byte, end_of_string);
            if (!in_valid || !in_stall) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 64);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pend_beats.size() != 0) begin
                    beat = pend_beats.pop_front();
                    burst_left--;
                    in_valid <= 1'b1;
                    data_byte <= beat.data;
                    end_of_string <= beat.eos;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall modes, plus one long hold-off to back the block up.
    int unsigned rx_cycle = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    t_rx_mode    rx_mode = RX_FREE;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle == HOLD_AT) hold_left = HOLD_LEN;
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= $urandom_range(0, 3) == 0;
                    RX_HALF:  out_stall <= $urandom_range(0, 1) == 0;
                    default:  out_stall <= $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_cp_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (exp_results.size() == 0) begin
                $error("unexpected result beat: cp_value %0h", cp_value);
                mismatches++;
            end else begin
                want = exp_results.pop_front();
                check_field("cp_value", 64'(want.cp), 64'(cp_value));
                check_field("is_printable", 64'(want.prn), 64'(is_printable));
                check_field("seq_length", 64'(want.len), 64'(seq_length));
                check_field("truncated", 64'(want.trunc), 64'(truncated));
                check_field("printable_count", 64'(want.count), 64'(printable_count));
                check_field("last", 64'(want.last), 64'(last));
            end
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int unsigned goal;
        int unsigned ncp;
        int unsigned len;
        int unsigned nb;
        int unsigned pick;
        t_cp_value   v;

        add_cp('0, 1, 1, 1'b0);
        add_cp(CP_SPACE, 1, 1, 1'b0);
        add_cp(42'h21, 1, 1, 1'b0);
        close_string();
        push_beat(8'h80);
        push_beat(8'hBF);
        close_string();
        add_cp(CP_NBSP, 2, 2, 1'b0);
        add_cp(CP_CGJ, 2, 2, 1'b0);
        add_cp(CP_BOM, 3, 3, 1'b0);
        add_cp(CP_NONCH, 3, 3, 1'b0);
        close_string();
        add_cp('1, 8, 8, 1'b0);
        close_string();
        push_beat(8'hE2);
        push_beat(8'hC3);
        push_beat(8'hA9);
        close_string();
        add_cp(42'h1F600, 4, 2, 1'b0);
        close_string();
        push_beat(8'hFE);
        close_string();

        goal = pend_beats.size() + RAND_BEATS;
        while (pend_beats.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                ncp = $urandom_range(1, 8);
                for (int c = 0; c < ncp; c++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        v = pick_special();
                        len = (v < 42'h80) ? 1 : (v < 42'h800) ? 2 : 3;
                        len = $urandom_range(len, 4);
                    end else begin
                        pick = $urandom_range(0, 19);
                        len = (pick < 8) ? 1 : (pick < 11) ? 2 : (pick < 14) ? 3 :
                              (pick < 17) ? 4 : $urandom_range(5, 8);
                        v = t_cp_value'({$urandom, $urandom}) &
                            ((t_cp_value'(1) << payload_bits(len)) - t_cp_value'(1));
                    end
                    nb = len;
                    if (c == ncp - 1 && len > 1 && $urandom_range(0, 9) == 0)
                        nb = $urandom_range(1, len - 1);
                    add_cp(v, len, nb, 1'b1);
                end
            end else if (pick < 90) begin
                nb = $urandom_range(1, 10);
                for (int i = 0; i < nb; i++) push_beat(8'($urandom_range(0, 255)));
            end else begin
                nb = $urandom_range(1, 6);
                for (int i = 0; i < nb; i++) push_beat(8'($urandom_range(8'h80, 8'hFF)));
            end
            close_string();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_beats.size() != 0 || in_valid || exp_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
